// ----- hw/rtl/bwsu_pkg.sv -----
// ----------------------------------------------------------------------------
// bwsu_pkg
// Shared types and constants of the breakpoint / watchpoint stop unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bwsu_pkg;

	localparam int BREAK_SLOTS    = 4;
	localparam int WATCH_SLOTS    = 4;
	localparam int NUM_BREAK_REGS = 4;
	localparam int NUM_WATCH_REGS = 4;

	localparam int ADDR_W   = 16;
	localparam int VALUE_W  = 8;
	localparam int ACCESS_W = 3;
	localparam int CYCLE_W  = 64;
	localparam int MODE_W   = 3;
	localparam int REASON_W = 3;

	localparam int BREAK_REG_W = ADDR_W + 1;
	localparam int WATCH_REG_W = ADDR_W + 2;
	localparam int CFG_DATA_W  = WATCH_REG_W;
	localparam int CFG_INDEX_W = 3;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 104;

	typedef enum logic [MODE_W-1:0] {
		MODE_FETCH     = 3'd0,
		MODE_ACCESS    = 3'd1,
		MODE_STEP_DONE = 3'd2,
		MODE_RESUME    = 3'd3,
		MODE_PREP_STEP = 3'd4,
		MODE_RT_RESET  = 3'd5
	} mode_t;

	typedef enum logic [REASON_W-1:0] {
		REASON_NONE  = 3'd0,
		REASON_BREAK = 3'd1,
		REASON_READ  = 3'd2,
		REASON_WRITE = 3'd3,
		REASON_STEP  = 3'd4
	} reason_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [ADDR_W-1:0]   address;
		logic [VALUE_W-1:0]  data_value;
		logic [ACCESS_W-1:0] access_kind;
		logic                is_write;
		logic [CYCLE_W-1:0]  cycle_count;
	} item_t;

	typedef struct packed {
		logic bp_hit;
		logic wp_read;
		logic wp_write;
	} match_t;

	typedef struct packed {
		logic                break_taken;
		logic                is_stopped;
		logic [REASON_W-1:0] stop_reason;
		logic [ADDR_W-1:0]   stop_address;
		logic [VALUE_W-1:0]  stop_value;
		logic [ACCESS_W-1:0] stop_access;
		logic                stop_write;
		logic [CYCLE_W-1:0]  stop_cycle;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/breakpoint_watchpoint_stop_unit_core.sv -----
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_stop_unit_core
// Debug stop unit: breakpoint / watchpoint match and stop record.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle unless m_tready holds the result beat; the
// stop record updates between the two registers.
// Reset clears slots, stop record, skip state and both stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_watchpoint_stop_unit_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bwsu_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bwsu_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// address[15:0], data_value[23:16], access_kind[26:24], is_write[27],
	// cycle_count[91:28], zero pad
	input  wire logic [bwsu_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode[2:0]
	input  wire logic [bwsu_pkg::MODE_W-1:0]      s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// break_taken[0], is_stopped[1], stop_reason[4:2], stop_address[20:5],
	// stop_value[28:21], stop_access[31:29], stop_write[32],
	// stop_cycle[96:33], zero pad
	output logic [bwsu_pkg::OUT_DATA_W-1:0]       m_tdata
);
	import bwsu_pkg::*;

	logic [BREAK_REG_W-1:0] brk_q [NUM_BREAK_REGS];
	logic [WATCH_REG_W-1:0] wch_q [NUM_WATCH_REGS];

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	match_t  match;
	result_t result;
	logic    advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BREAK_REGS; i++)
				brk_q[i] <= '0;
			for (int i = 0; i < NUM_WATCH_REGS; i++)
				wch_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index < CFG_INDEX_W'(NUM_BREAK_REGS))
				brk_q[cfg_index[1:0]] <= cfg_data[BREAK_REG_W-1:0];
			else
				wch_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode        <= s_tuser;
			item_s1.address     <= s_tdata[15:0];
			item_s1.data_value  <= s_tdata[23:16];
			item_s1.access_kind <= s_tdata[26:24];
			item_s1.is_write    <= s_tdata[27];
			item_s1.cycle_count <= s_tdata[91:28];
		end
	end

	bwsu_match u_match (
		.brk_slot (brk_q),
		.wch_slot (wch_q),
		.address  (item_s1.address),
		.match    (match)
	);

	bwsu_record u_record (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.match   (match),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.stop_cycle, res_s2.stop_write, res_s2.stop_access,
		res_s2.stop_value, res_s2.stop_address, res_s2.stop_reason,
		res_s2.is_stopped, res_s2.break_taken};

endmodule

`default_nettype wire

// ----- hw/rtl/bwsu_match.sv -----
// ----------------------------------------------------------------------------
// bwsu_match
// Address compare against the breakpoint and watchpoint slots.
// ----------------------------------------------------------------------------
`default_nettype none

module bwsu_match (
	input  wire logic [bwsu_pkg::BREAK_REG_W-1:0] brk_slot [bwsu_pkg::NUM_BREAK_REGS],
	input  wire logic [bwsu_pkg::WATCH_REG_W-1:0] wch_slot [bwsu_pkg::NUM_WATCH_REGS],
	input  wire logic [bwsu_pkg::ADDR_W-1:0]      address,
	output bwsu_pkg::match_t                      match
);
	import bwsu_pkg::*;

	logic       bp_hit;
	logic [1:0] wflags;

	always_comb begin
		bp_hit = 1'b0;
		for (int i = 0; i < BREAK_SLOTS; i++) begin
			if (brk_slot[i][ADDR_W] && brk_slot[i][ADDR_W-1:0] == address)
				bp_hit = 1'b1;
		end
	end

	// Walk from the last slot down so the first non-empty hit wins.
	always_comb begin
		wflags = 2'b00;
		for (int i = WATCH_SLOTS - 1; i >= 0; i--) begin
			if (wch_slot[i][ADDR_W+1:ADDR_W] != 2'b00 &&
			    wch_slot[i][ADDR_W-1:0] == address)
				wflags = wch_slot[i][ADDR_W+1:ADDR_W];
		end
	end

	assign match.bp_hit   = bp_hit;
	assign match.wp_read  = wflags[0];
	assign match.wp_write = wflags[1];

endmodule

`default_nettype wire

// ----- hw/rtl/bwsu_record.sv -----
// ----------------------------------------------------------------------------
// bwsu_record
// Stop record and one-shot skip; computes the result of one event.
// ----------------------------------------------------------------------------
`default_nettype none

module bwsu_record (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire bwsu_pkg::item_t  item,
	input  wire bwsu_pkg::match_t match,
	output bwsu_pkg::result_t     result
);
	import bwsu_pkg::*;

	logic [REASON_W-1:0] reason_q, reason_n;
	logic [ADDR_W-1:0]   addr_q, addr_n;
	logic [VALUE_W-1:0]  value_q, value_n;
	logic [ACCESS_W-1:0] access_q, access_n;
	logic                write_q, write_n;
	logic [CYCLE_W-1:0]  cycle_q, cycle_n;
	logic                skip_q, skip_n;
	logic [ADDR_W-1:0]   skip_addr_q, skip_addr_n;
	logic                taken;
	logic                rhit, whit;

	assign rhit = !item.is_write && match.wp_read;
	assign whit = item.is_write && match.wp_write;

	always_comb begin
		reason_n    = reason_q;
		addr_n      = addr_q;
		value_n     = value_q;
		access_n    = access_q;
		write_n     = write_q;
		cycle_n     = cycle_q;
		skip_n      = skip_q;
		skip_addr_n = skip_addr_q;
		taken       = 1'b0;
		unique case (item.mode)
			MODE_FETCH: begin
				skip_n = 1'b0;
				if (!(skip_q && item.address == skip_addr_q) && match.bp_hit) begin
					taken    = 1'b1;
					reason_n = REASON_BREAK;
					addr_n   = item.address;
					value_n  = '0;
					access_n = '0;
					write_n  = 1'b0;
					cycle_n  = item.cycle_count;
				end
			end
			MODE_ACCESS: begin
				if (reason_q == REASON_NONE && (rhit || whit)) begin
					reason_n = rhit ? REASON_READ : REASON_WRITE;
					addr_n   = item.address;
					value_n  = item.data_value;
					access_n = item.access_kind;
					write_n  = item.is_write;
					cycle_n  = item.cycle_count;
				end
			end
			MODE_STEP_DONE: begin
				if (reason_q == REASON_NONE) begin
					reason_n = REASON_STEP;
					addr_n   = item.address;
					value_n  = '0;
					access_n = '0;
					write_n  = 1'b0;
					cycle_n  = item.cycle_count;
				end
			end
			MODE_RESUME, MODE_PREP_STEP, MODE_RT_RESET: begin
				reason_n = REASON_NONE;
				addr_n   = '0;
				value_n  = '0;
				access_n = '0;
				write_n  = 1'b0;
				cycle_n  = '0;
				skip_n   = 1'b0;
				if (item.mode == MODE_RESUME && reason_q == REASON_BREAK) begin
					skip_n      = 1'b1;
					skip_addr_n = addr_q;
				end
				if (item.mode == MODE_RT_RESET)
					skip_addr_n = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reason_q    <= REASON_NONE;
			addr_q      <= '0;
			value_q     <= '0;
			access_q    <= '0;
			write_q     <= 1'b0;
			cycle_q     <= '0;
			skip_q      <= 1'b0;
			skip_addr_q <= '0;
		end else if (advance) begin
			reason_q    <= reason_n;
			addr_q      <= addr_n;
			value_q     <= value_n;
			access_q    <= access_n;
			write_q     <= write_n;
			cycle_q     <= cycle_n;
			skip_q      <= skip_n;
			skip_addr_q <= skip_addr_n;
		end
	end

	assign result.break_taken  = taken;
	assign result.is_stopped   = (reason_n != REASON_NONE);
	assign result.stop_reason  = reason_n;
	assign result.stop_address = addr_n;
	assign result.stop_value   = value_n;
	assign result.stop_access  = access_n;
	assign result.stop_write   = write_n;
	assign result.stop_cycle   = cycle_n;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the breakpoint / watchpoint stop unit. A model of
// the stop record and one-shot skip predicts each output beat. Directed
// events cover the special cases. Random debug sessions then run under
// several slot settings, with random gaps on both streams but for one back-to-back run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import bwsu_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
	localparam int REG_BREAK_0 = 0;
	localparam int REG_WATCH_0 = NUM_BREAK_REGS;
	localparam int NUM_REGS    = NUM_BREAK_REGS + NUM_WATCH_REGS;
	localparam int PIPE_LAT    = 2;
	localparam int DRAIN_LIMIT = 5000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [MODE_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;

	breakpoint_watchpoint_stop_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// model state
	logic [BREAK_REG_W-1:0] brk_reg [NUM_BREAK_REGS];
	logic [WATCH_REG_W-1:0] wch_reg [NUM_WATCH_REGS];
	logic [REASON_W-1:0]    rec_reason = '0;
	logic [ADDR_W-1:0]      rec_addr   = '0;
	logic [VALUE_W-1:0]     rec_value  = '0;
	logic [ACCESS_W-1:0]    rec_access = '0;
	logic                   rec_write  = 1'b0;
	logic [CYCLE_W-1:0]     rec_cycle  = '0;
	logic                   skip_armed = 1'b0;
	logic [ADDR_W-1:0]      skip_addr  = '0;

	result_t status_due [$];
	bit      gaps_on = 1'b1;
	int      mismatches = 0;
	int      n_events = 0;
	int      n_results = 0;
	int      n_skip = 0;
	int      n_stops [8];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("watchdog expired with %0d beats outstanding", status_due.size());
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 50)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic void clear_stop();
		rec_reason = REASON_NONE;
		rec_addr   = '0;
		rec_value  = '0;
		rec_access = '0;
		rec_write  = 1'b0;
		rec_cycle  = '0;
	endfunction

	function automatic void latch_stop(input logic [REASON_W-1:0] why,
			input logic [ADDR_W-1:0] a, input logic [VALUE_W-1:0] v,
			input logic [ACCESS_W-1:0] k, input logic w, input logic [CYCLE_W-1:0] c);
		rec_reason = why;
		rec_addr   = a;
		rec_value  = v;
		rec_access = k;
		rec_write  = w;
		rec_cycle  = c;
		n_stops[why]++;
	endfunction

	function automatic result_t predict_stop_status(input item_t ev);
		result_t    st;
		logic       hit;
		logic       skipped;
		logic       found;
		logic [1:0] flags;
		int         i;
		st = '0;
		hit = 1'b0;
		skipped = 1'b0;
		found = 1'b0;
		flags = 2'b00;
		case (ev.mode)
		MODE_FETCH: begin
			if (skip_armed) begin
				skipped = (ev.address == skip_addr);
				skip_armed = 1'b0;
			end
			for (i = 0; i < BREAK_SLOTS; i++)
				if (brk_reg[i][ADDR_W] && brk_reg[i][ADDR_W-1:0] == ev.address)
					hit = 1'b1;
			if (skipped)
				n_skip++;
			if (!skipped && hit) begin
				latch_stop(REASON_BREAK, ev.address, '0, '0, 1'b0, ev.cycle_count);
				st.break_taken = 1'b1;
			end
		end
		MODE_ACCESS: begin
			// first non-empty slot on this address decides
			for (i = 0; i < WATCH_SLOTS; i++)
				if (!found && wch_reg[i][ADDR_W+1:ADDR_W] != 2'b00 &&
						wch_reg[i][ADDR_W-1:0] == ev.address) begin
					flags = wch_reg[i][ADDR_W+1:ADDR_W];
					found = 1'b1;
				end
			if (rec_reason == REASON_NONE &&
					((!ev.is_write && flags[0]) || (ev.is_write && flags[1]))) begin
				if (ev.is_write)
					latch_stop(REASON_WRITE, ev.address, ev.data_value, ev.access_kind,
						ev.is_write, ev.cycle_count);
				else
					latch_stop(REASON_READ, ev.address, ev.data_value, ev.access_kind,
						ev.is_write, ev.cycle_count);
			end
		end
		MODE_STEP_DONE: begin
			if (rec_reason == REASON_NONE)
				latch_stop(REASON_STEP, ev.address, '0, '0, 1'b0, ev.cycle_count);
		end
		MODE_RESUME: begin
			skip_armed = (rec_reason == REASON_BREAK);
			if (skip_armed)
				skip_addr = rec_addr;
			clear_stop();
		end
		MODE_PREP_STEP: begin
			clear_stop();
			skip_armed = 1'b0;
		end
		MODE_RT_RESET: begin
			clear_stop();
			skip_armed = 1'b0;
			skip_addr = '0;
		end
		default: ;
		endcase
		st.is_stopped   = (rec_reason != REASON_NONE);
		st.stop_reason  = rec_reason;
		st.stop_address = rec_addr;
		st.stop_value   = rec_value;
		st.stop_access  = rec_access;
		st.stop_write   = rec_write;
		st.stop_cycle   = rec_cycle;
		return st;
	endfunction

	function automatic item_t fixed_event(input logic [MODE_W-1:0] m,
			input logic [ADDR_W-1:0] a, input logic [VALUE_W-1:0] v,
			input logic [ACCESS_W-1:0] k, input logic w, input logic [CYCLE_W-1:0] c);
		item_t ev;
		ev.mode        = m;
		ev.address     = a;
		ev.data_value  = v;
		ev.access_kind = k;
		ev.is_write    = w;
		ev.cycle_count = c;
		return ev;
	endfunction

	function automatic item_t make_event(input logic [MODE_W-1:0] m,
			input logic [ADDR_W-1:0] a);
		return fixed_event(m, a, VALUE_W'($urandom), ACCESS_W'($urandom), 1'($urandom),
			{$urandom, $urandom});
	endfunction

	// mostly addresses that some slot holds, so matches are frequent
	function automatic logic [ADDR_W-1:0] pick_addr();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4)
			return brk_reg[$urandom_range(NUM_BREAK_REGS-1)][ADDR_W-1:0];
		else if (pick < 8)
			return wch_reg[$urandom_range(NUM_WATCH_REGS-1)][ADDR_W-1:0];
		return ADDR_W'($urandom);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_event(input item_t ev);
		logic [IN_DATA_W-1:0] beat;
		beat = '0;
		beat[91:0] = {ev.cycle_count, ev.is_write, ev.access_kind, ev.data_value,
			ev.address};
		while (gaps_on && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		s_tuser  <= ev.mode;
		do @(posedge clk); while (!s_tready);
		status_due.push_back(predict_stop_status(ev));
		n_events++;
		@(negedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (status_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (PIPE_LAT + 2) @(negedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx[CFG_INDEX_W-1:0];
		cfg_data  <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx < NUM_BREAK_REGS)
			brk_reg[idx] = d[BREAK_REG_W-1:0];
		else
			wch_reg[idx-NUM_BREAK_REGS] = d[WATCH_REG_W-1:0];
	endtask

	task automatic load_random_slots();
		logic [CFG_DATA_W-1:0] d;
		logic [ADDR_W-1:0]     last;
		last = '0;
		drain();
		for (int i = 0; i < NUM_REGS; i++) begin
			d = CFG_DATA_W'($urandom);
			if (i > 0 && $urandom_range(2) == 0)
				d[ADDR_W-1:0] = last;
			last = d[ADDR_W-1:0];
			write_reg(i, d);
		end
	endtask

	task automatic load_uniform_slots(input logic [CFG_DATA_W-1:0] d);
		drain();
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(i, d);
	endtask

	task automatic random_events(input int count);
		int                sent;
		int                pick;
		logic [ADDR_W-1:0] a;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(9);
			if (pick < 4) begin
				// fetch a breakpoint slot's address, poke around, resume, mostly refetch the same opcode
				a = brk_reg[$urandom_range(NUM_BREAK_REGS-1)][ADDR_W-1:0];
				send_event(make_event(MODE_FETCH, a));
				send_event(make_event(MODE_ACCESS, pick_addr()));
				send_event(make_event(MODE_RESUME, ADDR_W'($urandom)));
				send_event(make_event(MODE_FETCH, $urandom_range(3) != 0 ? a : pick_addr()));
				sent += 4;
			end else if (pick < 7) begin
				a = wch_reg[$urandom_range(NUM_WATCH_REGS-1)][ADDR_W-1:0];
				send_event(make_event(MODE_ACCESS, a));
				send_event(make_event(MODE_STEP_DONE, pick_addr()));
				if ($urandom_range(1))
					send_event(make_event(MODE_RESUME, ADDR_W'($urandom)));
				else
					send_event(make_event(MODE_PREP_STEP, ADDR_W'($urandom)));
				sent += 3;
			end else begin
				send_event(make_event(MODE_W'($urandom_range(7)), pick_addr()));
				sent += 1;
			end
		end
	endtask

	task automatic test_idle_after_reset();
		send_event(fixed_event(MODE_FETCH, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd0));
		send_event(fixed_event(MODE_SPARE_6, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd0));
		send_event(fixed_event(MODE_SPARE_7, 16'hFFFF, 8'hFF, 3'd7, 1'b1, '1));
		send_event(fixed_event(MODE_STEP_DONE, 16'hFFFF, 8'hFF, 3'd7, 1'b1, '1));
		send_event(fixed_event(MODE_RESUME, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd0));
	endtask

	task automatic test_breakpoints();
		drain();
		write_reg(REG_BREAK_0 + 0, 18'h1_0000);
		write_reg(REG_BREAK_0 + 1, 18'h1_FFFF);
		write_reg(REG_BREAK_0 + 2, 18'h1_1234);
		write_reg(REG_BREAK_0 + 3, 18'h0_5678);
		send_event(fixed_event(MODE_FETCH, 16'h1234, 8'h5A, 3'd2, 1'b1, 64'd100));
		// new breakpoint replaces the pending one
		send_event(fixed_event(MODE_FETCH, 16'hFFFF, 8'h00, 3'd0, 1'b0, 64'd101));
		send_event(fixed_event(MODE_RESUME, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd102));
		send_event(fixed_event(MODE_FETCH, 16'hFFFF, 8'h00, 3'd0, 1'b0, 64'd103));
		send_event(fixed_event(MODE_FETCH, 16'hFFFF, 8'h00, 3'd0, 1'b0, 64'd104));
		send_event(fixed_event(MODE_RESUME, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd105));
		// other address consumes the skip and still hits
		send_event(fixed_event(MODE_FETCH, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd106));
		send_event(fixed_event(MODE_RESUME, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd107));
		send_event(fixed_event(MODE_PREP_STEP, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd108));
		send_event(fixed_event(MODE_FETCH, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd109));
		send_event(fixed_event(MODE_RT_RESET, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd110));
		send_event(fixed_event(MODE_FETCH, 16'h5678, 8'h00, 3'd0, 1'b0, 64'd111));
	endtask

	task automatic test_watchpoints();
		drain();
		write_reg(REG_WATCH_0 + 0, 18'h0_2000);
		write_reg(REG_WATCH_0 + 1, 18'h1_2000);
		write_reg(REG_WATCH_0 + 2, 18'h2_2000);
		write_reg(REG_WATCH_0 + 3, 18'h3_FFFF);
		send_event(fixed_event(MODE_ACCESS, 16'h2000, 8'hA5, 3'd3, 1'b0,
			64'h0123_4567_89AB_CDEF));
		send_event(fixed_event(MODE_FETCH, 16'h1234, 8'h00, 3'd0, 1'b0, 64'd200));
		send_event(fixed_event(MODE_PREP_STEP, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd201));
		send_event(fixed_event(MODE_ACCESS, 16'h2000, 8'h3C, 3'd1, 1'b1, 64'd202));
		send_event(fixed_event(MODE_ACCESS, 16'hFFFF, 8'hFF, 3'd7, 1'b1, '1));
		send_event(fixed_event(MODE_STEP_DONE, 16'h4444, 8'h00, 3'd0, 1'b0, 64'd203));
		send_event(fixed_event(MODE_RESUME, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd204));
		send_event(fixed_event(MODE_ACCESS, 16'hFFFF, 8'h00, 3'd0, 1'b0, 64'd205));
		send_event(fixed_event(MODE_RT_RESET, 16'h0000, 8'h00, 3'd0, 1'b0, 64'd206));
	endtask

	task automatic test_all_slots_max();
		load_uniform_slots('1);
		random_events(60);
	endtask

	task automatic test_all_slots_clear();
		load_uniform_slots('0);
		random_events(40);
	endtask

	task automatic test_back_to_back();
		load_random_slots();
		gaps_on = 1'b0;
		random_events(100);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_slots();
		repeat (4) begin
			load_random_slots();
			random_events(50);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= !(gaps_on && $urandom_range(99) < 11);
		end
	end

	task automatic check_field(input string name, input logic [CYCLE_W-1:0] got,
			input logic [CYCLE_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("beat %0d %s got %0h expected %0h", n_results, name,
				got, want));
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (status_due.size() == 0) begin
				report_mismatch($sformatf("beat %0d arrived with nothing expected", n_results));
			end else begin
				want = status_due.pop_front();
				check_field("break_taken", CYCLE_W'(m_tdata[0]),
					CYCLE_W'(want.break_taken));
				check_field("is_stopped", CYCLE_W'(m_tdata[1]),
					CYCLE_W'(want.is_stopped));
				check_field("stop_reason", CYCLE_W'(m_tdata[4:2]),
					CYCLE_W'(want.stop_reason));
				check_field("stop_address", CYCLE_W'(m_tdata[20:5]),
					CYCLE_W'(want.stop_address));
				check_field("stop_value", CYCLE_W'(m_tdata[28:21]),
					CYCLE_W'(want.stop_value));
				check_field("stop_access", CYCLE_W'(m_tdata[31:29]),
					CYCLE_W'(want.stop_access));
				check_field("stop_write", CYCLE_W'(m_tdata[32]),
					CYCLE_W'(want.stop_write));
				check_field("stop_cycle", m_tdata[96:33], want.stop_cycle);
			end
			n_results++;
		end
	end

	initial begin
		foreach (n_stops[i])
			n_stops[i] = 0;
		foreach (brk_reg[i])
			brk_reg[i] = '0;
		foreach (wch_reg[i])
			wch_reg[i] = '0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_after_reset();
		test_breakpoints();
		test_watchpoints();
		test_all_slots_max();
		test_all_slots_clear();
		test_back_to_back();
		test_random_slots();

		drain();
		if (status_due.size() != 0)
			report_mismatch($sformatf("%0d expected beats never arrived", status_due.size()));
		$display("ran %0d events, checked %0d result beats, %0d mismatches",
			n_events, n_results, mismatches);
		$display("stops: break %0d, read watch %0d, write watch %0d, step %0d, skips %0d",
			n_stops[REASON_BREAK], n_stops[REASON_READ], n_stops[REASON_WRITE],
			n_stops[REASON_STEP], n_skip);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
